// File: sv/ame_pkg.sv
// Shared types, codes and helpers for the accumulator machine execute block.
package ame_pkg;

  // Default sizes handed to the top level parameters
  localparam int MEM_DEPTH_DEF  = 16;
  localparam int WORD_WIDTH_DEF = 32;

  // Name codes
  localparam logic [4:0] REG_COUNT = 5'd14;
  localparam logic [4:0] CODE_ACC  = 5'd14;
  localparam logic [4:0] CODE_NULL = 5'd15;

  // Instruction opcodes
  typedef enum logic [3:0] {
    OP_SET   = 4'd0,
    OP_LOAD  = 4'd1,
    OP_ADD   = 4'd2,
    OP_INC   = 4'd3,
    OP_DEC   = 4'd4,
    OP_STORE = 4'd5,
    OP_SHOW  = 4'd6,
    OP_PAUSE = 4'd7,
    OP_END   = 4'd8
  } op_t;

  // Classified operation handed from front to back
  typedef enum logic [3:0] {
    K_NOP,
    K_SET,
    K_LOAD,
    K_ADD1,
    K_ADD2,
    K_ADD3,
    K_INC,
    K_DEC,
    K_STORE,
    K_SHOW_REG,
    K_SHOW_ACC
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  addr_a;
    logic [3:0]  addr_b;
    logic [3:0]  addr_c;
    logic [3:0]  code;
    logic [31:0] imm;
  } cmd_t;

  // Fixed constant of a register name: D1..D10 = 1..10, ICR..UC = 12..15
  function automatic logic [3:0] reg_const(input logic [3:0] code);
    logic [3:0] res;
    if (code < 4'd10) begin
      res = code + 4'd1;
    end else begin
      res = code + 4'd2;
    end
    return res;
  endfunction

endpackage

// File: sv/ame_ram.sv
// Generic RAM: one write port, two registered read ports.
module ame_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

// File: sv/ame_front.sv
// Front end: accept instructions, resolve operand names and classify them.
module ame_front (
  input  logic              push,
  input  logic              q_full,
  input  logic [3:0]        opcode,
  input  logic [4:0]        first_operand,
  input  logic [4:0]        second_operand,
  input  logic [4:0]        third_operand,
  input  logic [31:0]       immediate_value,
  output logic              enq,
  output ame_pkg::cmd_t     enq_cmd
);

  logic a_ok, b_ok, c_ok;
  ame_pkg::kind_t kind;

  assign a_ok = first_operand  < ame_pkg::REG_COUNT;
  assign b_ok = second_operand < ame_pkg::REG_COUNT;
  assign c_ok = third_operand  < ame_pkg::REG_COUNT;

  // Classify; a used operand that is not a register makes a no-op (bar ACC for show, NULL b/c for add)
  always_comb begin
    kind = ame_pkg::K_NOP;
    case (opcode)
      ame_pkg::OP_SET:   if (a_ok) kind = ame_pkg::K_SET;
      ame_pkg::OP_LOAD:  if (a_ok) kind = ame_pkg::K_LOAD;
      ame_pkg::OP_ADD: begin
        if (second_operand == ame_pkg::CODE_NULL && third_operand == ame_pkg::CODE_NULL) begin
          if (a_ok) kind = ame_pkg::K_ADD1;
        end else if (third_operand == ame_pkg::CODE_NULL) begin
          if (a_ok && b_ok) kind = ame_pkg::K_ADD2;
        end else begin
          if (a_ok && b_ok && c_ok) kind = ame_pkg::K_ADD3;
        end
      end
      ame_pkg::OP_INC:   if (a_ok) kind = ame_pkg::K_INC;
      ame_pkg::OP_DEC:   if (a_ok) kind = ame_pkg::K_DEC;
      ame_pkg::OP_STORE: if (a_ok) kind = ame_pkg::K_STORE;
      ame_pkg::OP_SHOW: begin
        if (first_operand == ame_pkg::CODE_ACC) begin
          kind = ame_pkg::K_SHOW_ACC;
        end else if (a_ok) begin
          kind = ame_pkg::K_SHOW_REG;
        end
      end
      ame_pkg::OP_PAUSE: kind = ame_pkg::K_NOP;
      ame_pkg::OP_END:   kind = ame_pkg::K_NOP;
      default:           kind = ame_pkg::K_NOP;
    endcase
  end

  // Build the command; drop no-ops here since they have no effect
  always_comb begin
    enq_cmd.kind   = kind;
    enq_cmd.addr_a = ame_pkg::reg_const(first_operand[3:0]);
    enq_cmd.addr_b = ame_pkg::reg_const(second_operand[3:0]);
    enq_cmd.addr_c = ame_pkg::reg_const(third_operand[3:0]);
    enq_cmd.code   = first_operand[3:0];
    enq_cmd.imm    = immediate_value;
  end

  assign enq = push && !q_full && (kind != ame_pkg::K_NOP);

endmodule

// File: sv/ame_cmdq.sv
// Two-entry command queue between front end and back end.
module ame_cmdq (
  input  logic          clk,
  input  logic          rst,
  input  logic          enq,
  input  ame_pkg::cmd_t enq_cmd,
  output logic          full,
  input  logic          deq,
  output logic          nonempty,
  output ame_pkg::cmd_t head_cmd
);

  ame_pkg::cmd_t entry [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full     = count == 2'd2;
  assign nonempty = count != 2'd0;
  assign head_cmd = entry[rd_ptr];

  // Store incoming commands
  always_ff @(posedge clk) begin
    if (enq) begin
      entry[wr_ptr] <= enq_cmd;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (enq) wr_ptr <= !wr_ptr;
      if (deq) rd_ptr <= !rd_ptr;
      if (enq && !deq) begin
        count <= count + 2'd1;
      end else if (deq && !enq) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// File: sv/ame_back.sv
// Back end: read operands, execute, update memory and accumulator, hold the result.
module ame_back #(
  parameter int MEM_DEPTH  = ame_pkg::MEM_DEPTH_DEF,
  parameter int WORD_WIDTH = ame_pkg::WORD_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_nonempty,
  input  ame_pkg::cmd_t q_head,
  output logic          deq,
  output logic          empty,
  input  logic          pop,
  output logic [3:0]    shown_code,
  output logic [31:0]   shown_value
);

  localparam int AW = $clog2(MEM_DEPTH);

  typedef enum logic [1:0] {
    ST_ISSUE = 2'b01,
    ST_EXEC  = 2'b10
  } state_t;

  state_t              state;
  ame_pkg::cmd_t       cmd;
  logic [WORD_WIDTH-1:0] acc;
  logic [MEM_DEPTH-1:0]  valid;
  logic                  rvalid0, rvalid1;
  logic [WORD_WIDTH-1:0] rdata0, rdata1, m0, m1;
  logic [WORD_WIDTH-1:0] sum, wdata;
  logic [AW-1:0]         waddr;
  logic                  we;
  logic                  out_valid;
  logic                  is_show, stall, exec;
  logic signed [63:0]    imm_ext, acc_ext;

  assign deq = (state == ST_ISSUE) && q_nonempty;

  ame_ram #(
    .WIDTH(WORD_WIDTH),
    .DEPTH(MEM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (deq),
    .raddr0(AW'(q_head.addr_a)),
    .raddr1(AW'(q_head.addr_b)),
    .rdata0(rdata0),
    .rdata1(rdata1)
  );

  // Words never written read as zero
  assign m0 = rvalid0 ? rdata0 : '0;
  assign m1 = rvalid1 ? rdata1 : '0;

  assign is_show = (cmd.kind == ame_pkg::K_SHOW_REG) || (cmd.kind == ame_pkg::K_SHOW_ACC);
  assign stall   = is_show && out_valid && !pop;
  assign exec    = (state == ST_EXEC) && !stall;

  assign sum     = acc + m0 + ((cmd.kind == ame_pkg::K_ADD1) ? '0 : m1);
  assign imm_ext = 64'(signed'(cmd.imm));
  assign acc_ext = 64'(signed'(acc));

  // Select the memory write
  always_comb begin
    we    = 1'b0;
    waddr = AW'(cmd.addr_a);
    wdata = m0;
    case (cmd.kind)
      ame_pkg::K_SET: begin
        we    = exec;
        wdata = imm_ext[WORD_WIDTH-1:0];
      end
      ame_pkg::K_INC: begin
        we    = exec;
        wdata = m0 + WORD_WIDTH'(1);
      end
      ame_pkg::K_DEC: begin
        we    = exec;
        wdata = m0 - WORD_WIDTH'(1);
      end
      ame_pkg::K_STORE: begin
        we    = exec;
        wdata = acc;
      end
      ame_pkg::K_ADD3: begin
        we    = exec;
        waddr = AW'(cmd.addr_c);
        wdata = sum;
      end
      default: we = 1'b0;
    endcase
  end

  // Latch the issued command and the valid bits of its operands
  always_ff @(posedge clk) begin
    if (deq) begin
      cmd     <= q_head;
      rvalid0 <= valid[AW'(q_head.addr_a)];
      rvalid1 <= valid[AW'(q_head.addr_b)];
    end
  end

  // Sequence issue and execute
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ISSUE;
    end else begin
      case (state)
        ST_ISSUE: if (deq) state <= ST_EXEC;
        ST_EXEC:  if (!stall) state <= ST_ISSUE;
        default:  state <= ST_ISSUE;
      endcase
    end
  end

  // Update valid bits and the accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      acc   <= '0;
    end else begin
      if (we) valid[waddr] <= 1'b1;
      if (exec) begin
        case (cmd.kind)
          ame_pkg::K_LOAD: acc <= m0;
          ame_pkg::K_ADD1,
          ame_pkg::K_ADD2,
          ame_pkg::K_ADD3: acc <= sum;
          default:         acc <= acc;
        endcase
      end
    end
  end

  // Hold the result until popped
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec && is_show) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec && is_show) begin
      if (cmd.kind == ame_pkg::K_SHOW_ACC) begin
        shown_code  <= ame_pkg::CODE_ACC[3:0];
        shown_value <= acc_ext[31:0];
      end else begin
        shown_code  <= cmd.code;
        shown_value <= {28'd0, ame_pkg::reg_const(cmd.code)};
      end
    end
  end

  assign empty = !out_valid;

endmodule

// File: sv/accumulator_machine_execute_top.sv
// Accumulator machine execute block: front end, command queue and back end.
// Flow: the back end takes one instruction at a time, reading the single data memory
// and then writing it; no-op instructions are dropped by the front end and never queued.
// Reset: rst (synchronous) empties the queue and result register, zeroes the
// accumulator and clears the memory valid bits so every word reads as zero.
module accumulator_machine_execute_top #(
  parameter int MEM_DEPTH  = ame_pkg::MEM_DEPTH_DEF,
  parameter int WORD_WIDTH = ame_pkg::WORD_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [3:0]  opcode,
  input  logic [4:0]  first_operand,
  input  logic [4:0]  second_operand,
  input  logic [4:0]  third_operand,
  input  logic [31:0] immediate_value,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  shown_code,
  output logic [31:0] shown_value
);

  logic          enq, deq, q_nonempty;
  ame_pkg::cmd_t enq_cmd, head_cmd;

  ame_front u_front (
    .push           (push),
    .q_full         (full),
    .opcode         (opcode),
    .first_operand  (first_operand),
    .second_operand (second_operand),
    .third_operand  (third_operand),
    .immediate_value(immediate_value),
    .enq            (enq),
    .enq_cmd        (enq_cmd)
  );

  ame_cmdq u_cmdq (
    .clk     (clk),
    .rst     (rst),
    .enq     (enq),
    .enq_cmd (enq_cmd),
    .full    (full),
    .deq     (deq),
    .nonempty(q_nonempty),
    .head_cmd(head_cmd)
  );

  ame_back #(
    .MEM_DEPTH (MEM_DEPTH),
    .WORD_WIDTH(WORD_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_nonempty),
    .q_head     (head_cmd),
    .deq        (deq),
    .empty      (empty),
    .pop        (pop),
    .shown_code (shown_code),
    .shown_value(shown_value)
  );

endmodule

// File: tb/sv/tb_accumulator_machine_execute_top.sv
// Self-checking testbench for the accumulator machine execute block.
module tb_accumulator_machine_execute_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Name codes and values used by the stimulus
  localparam logic [4:0] CODE_D1    = 5'd0;
  localparam logic [4:0] CODE_D2    = 5'd1;
  localparam logic [4:0] CODE_D3    = 5'd2;
  localparam logic [4:0] CODE_ICR   = 5'd10;
  localparam logic [4:0] CODE_MDR   = 5'd12;
  localparam logic [4:0] CODE_UC    = 5'd13;
  localparam logic [4:0] CODE_OTHER = 5'd16;
  localparam logic [4:0] CODE_MAX   = 5'd31;
  localparam logic [3:0] OP_SPARE_LO = 4'd9;
  localparam logic [3:0] OP_SPARE_HI = 4'd15;
  localparam logic [31:0] WORD_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] WORD_MIN  = 32'h8000_0000;
  localparam logic [31:0] WORD_ONES = 32'hFFFF_FFFF;

  localparam int RANDOM_ITEMS  = 850;
  localparam int LONG_HOLD     = 600;
  localparam int HOLD_AFTER    = 300;
  localparam int DRAIN_CYCLES  = 10;
  localparam int CYCLE_LIMIT   = 400000;

  typedef struct packed {
    logic [3:0]  op;
    logic [4:0]  a;
    logic [4:0]  b;
    logic [4:0]  c;
    logic [31:0] imm;
    bit          wait_idle;
  } instr_t;

  typedef struct packed {
    logic [3:0]  code;
    logic [31:0] value;
  } shown_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [3:0]  opcode = '0;
  logic [4:0]  first_operand = '0;
  logic [4:0]  second_operand = '0;
  logic [4:0]  third_operand = '0;
  logic [31:0] immediate_value = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [3:0]  shown_code;
  logic [31:0] shown_value;

  accumulator_machine_execute_top dut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .opcode(opcode), .first_operand(first_operand),
    .second_operand(second_operand), .third_operand(third_operand),
    .immediate_value(immediate_value),
    .empty(empty), .pop(pop), .shown_code(shown_code), .shown_value(shown_value)
  );

  // Machine state mirrored by the predictor
  logic [31:0] mem_words [16];
  logic [31:0] acc_word;

  instr_t instr_q[$];
  shown_t shown_q[$];

  int fails = 0;
  int accepted = 0;
  int shows_seen = 0;
  int directed_count = 0;
  int cycles = 0;

  // Clock
  initial begin
    forever #10 clk = ~clk;
  end

  // Memory address that a register name stands for
  function automatic logic [3:0] name_addr(logic [4:0] code);
    return (code < 5'd10) ? code[3:0] + 4'd1 : code[3:0] + 4'd2;
  endfunction

  // Execute one instruction on the mirrored state, queue any shown result
  function automatic void run_instr(instr_t it);
    logic [3:0] a, b, c;
    bit ra, rb, rc;
    shown_t s;
    a = name_addr(it.a);
    b = name_addr(it.b);
    c = name_addr(it.c);
    ra = it.a < ame_pkg::REG_COUNT;
    rb = it.b < ame_pkg::REG_COUNT;
    rc = it.c < ame_pkg::REG_COUNT;
    case (it.op)
      ame_pkg::OP_SET: if (ra) mem_words[a] = it.imm;
      ame_pkg::OP_LOAD: if (ra) acc_word = mem_words[a];
      ame_pkg::OP_ADD: begin
        if (it.b == ame_pkg::CODE_NULL && it.c == ame_pkg::CODE_NULL) begin
          if (ra) acc_word = acc_word + mem_words[a];
        end else if (it.c == ame_pkg::CODE_NULL) begin
          if (ra && rb) acc_word = acc_word + mem_words[a] + mem_words[b];
        end else if (ra && rb && rc) begin
          acc_word = acc_word + mem_words[a] + mem_words[b];
          mem_words[c] = acc_word;
        end
      end
      ame_pkg::OP_INC: if (ra) mem_words[a] = mem_words[a] + 32'd1;
      ame_pkg::OP_DEC: if (ra) mem_words[a] = mem_words[a] - 32'd1;
      ame_pkg::OP_STORE: if (ra) mem_words[a] = acc_word;
      ame_pkg::OP_SHOW: begin
        if (it.a == ame_pkg::CODE_ACC) begin
          s.code = ame_pkg::CODE_ACC[3:0];
          s.value = acc_word;
          shown_q.push_back(s);
        end else if (ra) begin
          s.code = it.a[3:0];
          s.value = {28'd0, a};
          shown_q.push_back(s);
        end
      end
      default: ;
    endcase
  endfunction

  task automatic add_instr(logic [3:0] op, logic [4:0] a, logic [4:0] b, logic [4:0] c,
                           logic [31:0] imm);
    instr_t it;
    it.op = op;
    it.a = a;
    it.b = b;
    it.c = c;
    it.imm = imm;
    it.wait_idle = 1'b0;
    instr_q.push_back(it);
  endtask

  // Mostly register names, sometimes ACC, NULL or another name
  function automatic logic [4:0] pick_name(int reg_pct);
    logic [4:0] n;
    if ($urandom_range(0, 99) < reg_pct) begin
      n = 5'($urandom_range(0, 13));
    end else begin
      case ($urandom_range(0, 3))
        0: n = ame_pkg::CODE_ACC;
        1: n = ame_pkg::CODE_NULL;
        2: n = CODE_OTHER;
        default: n = 5'($urandom_range(CODE_OTHER, CODE_MAX));
      endcase
    end
    return n;
  endfunction

  function automatic logic [31:0] pick_imm();
    logic [31:0] v;
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = WORD_MAX;
      2: v = WORD_MIN;
      3: v = WORD_ONES;
      4: v = $urandom_range(0, 16);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic instr_t rand_instr();
    instr_t it;
    int r;
    r = $urandom_range(0, 99);
    it.wait_idle = 1'b0;
    it.imm = pick_imm();
    it.a = pick_name(90);
    it.b = pick_name(90);
    it.c = pick_name(90);
    if (r < 3) begin
      // raw noise across the full field widths
      it.op = 4'($urandom);
      it.a = 5'($urandom);
      it.b = 5'($urandom);
      it.c = 5'($urandom);
    end else if (r < 16) it.op = ame_pkg::OP_SET;
    else if (r < 26) it.op = ame_pkg::OP_LOAD;
    else if (r < 46) begin
      it.op = ame_pkg::OP_ADD;
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: begin it.b = ame_pkg::CODE_NULL; it.c = ame_pkg::CODE_NULL; end
        6, 7, 8, 9, 10, 11: it.c = ame_pkg::CODE_NULL;
        12: it.b = ame_pkg::CODE_NULL;
        default: ;
      endcase
    end
    else if (r < 54) it.op = ame_pkg::OP_INC;
    else if (r < 62) it.op = ame_pkg::OP_DEC;
    else if (r < 70) it.op = ame_pkg::OP_STORE;
    else if (r < 92) it.op = ame_pkg::OP_SHOW;
    else if (r < 95) begin
      it.op = ($urandom_range(0, 1) == 0) ? ame_pkg::OP_PAUSE : ame_pkg::OP_END;
    end
    else it.op = 4'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    return it;
  endfunction

  // Sender: offer queued instructions in bursts, hold while full
  int burst_left = 8;
  int gap_left = 0;
  always @(posedge clk) begin
    bit offer;
    instr_t nxt;
    offer = 1'b0;
    nxt = '0;
    if (!rst && !(push && full)) begin
      if (push) begin
        run_instr(instr_q.pop_front());
        accepted++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      if (gap_left > 0) begin
        gap_left--;
      end else if (instr_q.size() > 0) begin
        if (!instr_q[0].wait_idle || shown_q.size() == 0) begin
          offer = 1'b1;
          nxt = instr_q[0];
        end
      end
      push <= offer;
      if (offer) begin
        opcode <= nxt.op;
        first_operand <= nxt.a;
        second_operand <= nxt.b;
        third_operand <= nxt.c;
        immediate_value <= nxt.imm;
      end
    end
  end

  // Receiver: check each result transaction and stall on its own pattern
  int stall_mode = 0;
  int mode_cycles = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    shown_t want;
    bit take;
    take = 1'b0;
    if (!rst) begin
      if (pop && !empty) begin
        if (shown_q.size() == 0) begin
          $error("unexpected result: shown_code %0d shown_value %0h", shown_code, shown_value);
          fails++;
        end else begin
          want = shown_q.pop_front();
          shows_seen++;
          if (shown_code !== want.code) begin
            $error("shown_code: expected %0d, actual %0d", want.code, shown_code);
            fails++;
          end
          if (shown_value !== want.value) begin
            $error("shown_value: expected %0h, actual %0h", want.value, shown_value);
            fails++;
          end
        end
      end
      // one long hold-off so the block backs up and stalls its input
      if (!hold_done && accepted >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
      end else begin
        case (stall_mode)
          0: take = 1'b1;
          1: take = 1'($urandom_range(0, 1));
          2: take = ($urandom_range(0, 3) == 0);
          default: take = ($urandom_range(0, 9) != 0);
        endcase
      end
      mode_cycles++;
      if (mode_cycles == 150) begin
        mode_cycles = 0;
        stall_mode = $urandom_range(0, 3);
      end
      pop <= take;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[accumulator_machine_execute_top] ERROR");
      $finish;
    end
  end

  // Stimulus and end of run
  initial begin
    instr_t it;
    int counted;
    for (int i = 0; i < 16; i++) mem_words[i] = '0;
    acc_word = '0;

    // Directed: extremes, every operation, skipped operands and the add forms
    add_instr(ame_pkg::OP_SET, CODE_D1, ame_pkg::CODE_NULL, ame_pkg::CODE_NULL, WORD_MAX);
    add_instr(ame_pkg::OP_SET, CODE_UC, ame_pkg::CODE_NULL, ame_pkg::CODE_NULL, WORD_MIN);
    add_instr(ame_pkg::OP_SET, ame_pkg::CODE_ACC, ame_pkg::CODE_NULL, ame_pkg::CODE_NULL,
              WORD_ONES);
    add_instr(ame_pkg::OP_SET, CODE_MAX, CODE_MAX, CODE_MAX, WORD_ONES);
    add_instr(ame_pkg::OP_LOAD, CODE_D1, ame_pkg::CODE_NULL, ame_pkg::CODE_NULL, '0);
    add_instr(ame_pkg::OP_SHOW, ame_pkg::CODE_ACC, ame_pkg::CODE_NULL, ame_pkg::CODE_NULL,
              '0);
    add_instr(ame_pkg::OP_INC, CODE_D1, ame_pkg::CODE_NULL, ame_pkg::CODE_NULL, '0);
    add_instr(ame_pkg::OP_DEC, CODE_D2, ame_pkg::CODE_NULL, ame_pkg::CODE_NULL, '0);
    add_instr(ame_pkg::OP_ADD, CODE_D1, ame_pkg::CODE_NULL, ame_pkg::CODE_NULL, '0);
    add_instr(ame_pkg::OP_ADD, CODE_D2, CODE_UC, ame_pkg::CODE_NULL, '0);
    add_instr(ame_pkg::OP_ADD, CODE_D1, CODE_D2, CODE_MDR, '0);
    add_instr(ame_pkg::OP_ADD, CODE_D1, ame_pkg::CODE_NULL, CODE_D3, '0);
    add_instr(ame_pkg::OP_ADD, ame_pkg::CODE_ACC, CODE_D1, ame_pkg::CODE_NULL, '0);
    add_instr(ame_pkg::OP_STORE, CODE_ICR, ame_pkg::CODE_NULL, ame_pkg::CODE_NULL, '0);
    add_instr(ame_pkg::OP_LOAD, CODE_MDR, ame_pkg::CODE_NULL, ame_pkg::CODE_NULL, '0);
    add_instr(ame_pkg::OP_SHOW, ame_pkg::CODE_ACC, ame_pkg::CODE_NULL, ame_pkg::CODE_NULL,
              '0);
    add_instr(ame_pkg::OP_SHOW, CODE_D1, ame_pkg::CODE_NULL, ame_pkg::CODE_NULL, '0);
    add_instr(ame_pkg::OP_SHOW, CODE_UC, ame_pkg::CODE_NULL, ame_pkg::CODE_NULL, '0);
    add_instr(ame_pkg::OP_SHOW, ame_pkg::CODE_NULL, ame_pkg::CODE_NULL, ame_pkg::CODE_NULL,
              '0);
    add_instr(ame_pkg::OP_SHOW, CODE_OTHER, ame_pkg::CODE_NULL, ame_pkg::CODE_NULL, '0);
    add_instr(ame_pkg::OP_PAUSE, CODE_D1, CODE_D2, CODE_D3, WORD_ONES);
    add_instr(ame_pkg::OP_END, ame_pkg::CODE_NULL, ame_pkg::CODE_NULL, ame_pkg::CODE_NULL,
              '0);
    add_instr(OP_SPARE_HI, CODE_MAX, CODE_MAX, CODE_MAX, WORD_ONES);
    add_instr(ame_pkg::OP_INC, ame_pkg::CODE_ACC, ame_pkg::CODE_NULL, ame_pkg::CODE_NULL, '0);
    add_instr(ame_pkg::OP_SHOW, ame_pkg::CODE_ACC, ame_pkg::CODE_NULL, ame_pkg::CODE_NULL,
              '0);
    directed_count = instr_q.size();

    // Random part; every 200 items the sender waits for all results first
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      it = rand_instr();
      if (counted % 200 == 0) it.wait_idle = 1'b1;
      counted++;
      instr_q.push_back(it);
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Wait for the last transaction, then for all results, then let it settle
    while (instr_q.size() != 0 || push) @(posedge clk);
    while (shown_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d instructions (%0d directed), checked %0d shown results, %0d mismatches",
             accepted, directed_count, shows_seen, fails);
    if (fails == 0) begin
      $display("[accumulator_machine_execute_top] OK");
    end else begin
      $display("[accumulator_machine_execute_top] ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/ame_pkg.sv
sv/ame_ram.sv
sv/ame_front.sv
sv/ame_cmdq.sv
sv/ame_back.sv
sv/accumulator_machine_execute_top.sv
tb/sv/tb_accumulator_machine_execute_top.sv
